@@ rtl/slab_pkg.sv @@
`default_nettype none
package slab_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int MAX_SLOTS_DEF  = 32;

  localparam int HANDLE_W = 9;
  localparam int CFG_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 6'd32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_ALLOC,
    S_ALINK,
    S_DIV,
    S_FCHK,
    S_FREE,
    S_FIX
  } state_t;

endpackage
`default_nettype wire

@@ rtl/slab_ifs.sv @@
`default_nettype none
interface slab_req_if;
  import slab_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [HANDLE_W-1:0] handle;
  modport source (output valid, opcode, handle, input ready);
  modport sink   (input valid, opcode, handle, output ready);
endinterface

interface slab_rsp_if;
  import slab_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] slot_handle;
  logic                block_released;
  modport source (output valid, status, slot_handle, block_released, input ready);
  modport sink   (input valid, status, slot_handle, block_released, output ready);
endinterface

interface slab_cfg_if;
  import slab_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/slab_slot_allocator_core.sv @@
`default_nettype none
// Two-level slot allocator over a pool of NUM_BLOCKS blocks. An allocate request
// returns a slot from the block at the head of the partial-block list, taking the
// lowest free block when that list is empty; a free request pushes the slot on its
// block's stack and may release the block. One request is in flight at a time and
// the next is accepted once the previous result has been taken. An allocate from the
// list head first reads the block and list memories, and a slot that comes off a freed
// stack deeper than one needs a further slot-memory read; a free runs a 9-step serial
// divide of the handle by the slot count, then one read of the block and slot memories
// (plus a list fix-up step when a full block returns to a non-empty list).
// The slot count register is taken only while no block is allocated.
module slab_slot_allocator_core #(
  parameter int NUM_BLOCKS = slab_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_SLOTS  = slab_pkg::MAX_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  slab_req_if.sink    in_ch,
  slab_rsp_if.source  out_ch,
  slab_cfg_if.sink    cfg_ch
);
  import slab_pkg::*;

  localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW   = $clog2(NUM_BLOCKS + 1);
  localparam int SLW  = $clog2(MAX_SLOTS);
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int AW   = $clog2(NUM_BLOCKS * MAX_SLOTS);
  localparam int RW   = 3 * CW;
  localparam int SMW  = 1 + SLW;
  localparam int CNTW = $clog2(HANDLE_W + 1);

  localparam logic [LW-1:0]   NONE   = LW'(NUM_BLOCKS);
  localparam logic [CW-1:0]   MAXC   = CW'(MAX_SLOTS);
  localparam logic [CNTW-1:0] DIV_N  = CNTW'(HANDLE_W);

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                              input logic [SLW-1:0] s);
    slot_addr = AW'(int'(b) * MAX_SLOTS + int'(s));
  endfunction

  // control state
  state_t                state_r, state_nxt;
  logic [NUM_BLOCKS-1:0] taken_r, taken_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [CFG_W-1:0]      slots_r, slots_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // working payload
  logic [BW-1:0]         b_r, b_nxt;
  logic [SLW-1:0]        slot_r, slot_nxt;
  logic [CW-1:0]         fc_r, fc_nxt;
  logic [CW-1:0]         fr_r, fr_nxt;
  logic [CW-1:0]         top_r, top_nxt;
  logic [LW-1:0]         hnext_r, hnext_nxt;
  logic [HANDLE_W-1:0]   dvd_r, dvd_nxt;
  logic [HANDLE_W-1:0]   q_r, q_nxt;
  logic [CFG_W-1:0]      rem_r, rem_nxt;
  status_t               status_r, status_nxt;
  logic [HANDLE_W-1:0]   hout_r, hout_nxt;
  logic                  rel_r, rel_nxt;

  // memories
  logic [RW-1:0]  bm_mem [NUM_BLOCKS];
  logic [LW-1:0]  ln_mem [NUM_BLOCKS];
  logic [LW-1:0]  lp_mem [NUM_BLOCKS];
  logic [SMW-1:0] sm_mem [NUM_BLOCKS*MAX_SLOTS];
  logic [RW-1:0]  bm_rd_r;
  logic [LW-1:0]  ln_rd_r;
  logic [LW-1:0]  lp_rd_r;
  logic [SMW-1:0] sm_rd_r;

  logic           bm_we, ln_we, lp_we, sm_we;
  logic [BW-1:0]  bm_wa, ln_wa, lp_wa, bm_ra, ln_ra, lp_ra;
  logic [AW-1:0]  sm_wa, sm_ra;
  logic [RW-1:0]  bm_wd;
  logic [LW-1:0]  ln_wd, lp_wd;
  logic [SMW-1:0] sm_wd;

  logic [CFG_W-1:0] s_eff;
  logic             in_ready;
  logic [BW-1:0]    ff_idx;
  logic             ff_found;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    if (slots_r == '0) begin
      s_eff = CFG_W'(1);
    end else if (int'(slots_r) > MAX_SLOTS) begin
      s_eff = CFG_W'(MAX_SLOTS);
    end else begin
      s_eff = slots_r;
    end
  end

  // lowest block not taken
  always_comb begin
    ff_idx   = '0;
    ff_found = 1'b0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!taken_r[i]) begin
        ff_idx   = BW'(i);
        ff_found = 1'b1;
      end
    end
  end

  always_comb begin
    logic [CFG_W:0]  t;
    logic            fin_alloc;
    logic [SLW-1:0]  a_slot;
    logic [CW-1:0]   a_top;
    logic [CW-1:0]   a_fr;
    logic [CW-1:0]   f_fc, f_fr, f_top;
    logic            f_full, f_rel;
    logic [SLW-1:0]  f_link;

    state_nxt     = state_r;
    taken_nxt     = taken_r;
    head_nxt      = head_r;
    slots_nxt     = slots_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    b_nxt         = b_r;
    slot_nxt      = slot_r;
    fc_nxt        = fc_r;
    fr_nxt        = fr_r;
    top_nxt       = top_r;
    hnext_nxt     = hnext_r;
    dvd_nxt       = dvd_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    status_nxt    = status_r;
    hout_nxt      = hout_r;
    rel_nxt       = rel_r;

    bm_we = 1'b0; bm_wa = b_r; bm_wd = '0; bm_ra = b_r;
    ln_we = 1'b0; ln_wa = b_r; ln_wd = '0; ln_ra = b_r;
    lp_we = 1'b0; lp_wa = b_r; lp_wd = '0; lp_ra = b_r;
    sm_we = 1'b0; sm_wa = slot_addr(b_r, slot_r); sm_wd = '0;
    sm_ra = slot_addr(b_r, slot_r);

    t         = '0;
    fin_alloc = 1'b0;
    a_slot    = slot_r;
    a_top     = top_r;
    a_fr      = fr_r;
    f_fc      = bm_rd_r[RW-1 -: CW];
    f_fr      = bm_rd_r[2*CW-1 -: CW];
    f_top     = bm_rd_r[CW-1:0];
    f_full    = (f_fc == '0);
    f_link    = sm_rd_r[SLW-1:0];
    f_rel     = (int'(f_fc) + 1 >= int'(s_eff)) &&
                (f_full ? (head_r != NONE) : (ln_rd_r != NONE));

    if (cfg_ch.valid && !(|taken_r)) begin
      slots_nxt = cfg_ch.data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ready) begin
          if (in_ch.opcode == OP_ALLOC) begin
            if (head_r != NONE) begin
              bm_ra     = head_r[BW-1:0];
              ln_ra     = head_r[BW-1:0];
              b_nxt     = head_r[BW-1:0];
              state_nxt = S_ARD;
            end else if (ff_found) begin
              // take a fresh block and put it on the empty list
              taken_nxt[ff_idx] = 1'b1;
              bm_we     = 1'b1;
              bm_wa     = ff_idx;
              bm_wd     = {CW'(s_eff), CW'(s_eff), MAXC};
              ln_we     = 1'b1;
              ln_wa     = ff_idx;
              ln_wd     = NONE;
              lp_we     = 1'b1;
              lp_wa     = ff_idx;
              lp_wd     = NONE;
              head_nxt  = LW'(ff_idx);
              b_nxt     = ff_idx;
              fc_nxt    = CW'(s_eff);
              fr_nxt    = CW'(s_eff);
              top_nxt   = MAXC;
              hnext_nxt = NONE;
              state_nxt = S_ALLOC;
            end else begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_EXHAUSTED;
              hout_nxt      = '0;
              rel_nxt       = 1'b0;
            end
          end else begin
            dvd_nxt   = in_ch.handle;
            q_nxt     = '0;
            rem_nxt   = '0;
            cnt_nxt   = DIV_N;
            state_nxt = S_DIV;
          end
        end
      end

      S_ARD: begin
        fc_nxt    = bm_rd_r[RW-1 -: CW];
        fr_nxt    = bm_rd_r[2*CW-1 -: CW];
        top_nxt   = bm_rd_r[CW-1:0];
        hnext_nxt = ln_rd_r;
        state_nxt = S_ALLOC;
      end

      S_ALLOC: begin
        if (fc_r > fr_r) begin
          a_slot = (top_r >= MAXC) ? '0 : SLW'(top_r);
          if (CW'(fc_r - fr_r) > CW'(1)) begin
            // fetch the link below the stack top
            slot_nxt  = a_slot;
            sm_ra     = slot_addr(b_r, a_slot);
            state_nxt = S_ALINK;
          end else begin
            a_top     = MAXC;
            fin_alloc = 1'b1;
          end
        end else begin
          a_fr      = fr_r - CW'(1);
          a_slot    = SLW'(fr_r - CW'(1));
          fin_alloc = 1'b1;
        end
      end

      S_ALINK: begin
        a_slot    = slot_r;
        a_top     = CW'(sm_rd_r[SLW-1:0]);
        fin_alloc = 1'b1;
      end

      S_DIV: begin
        t = {rem_r, dvd_r[HANDLE_W-1]};
        if (t >= {1'b0, s_eff}) begin
          rem_nxt = CFG_W'(t - {1'b0, s_eff});
          q_nxt   = {q_r[HANDLE_W-2:0], 1'b1};
        end else begin
          rem_nxt = t[CFG_W-1:0];
          q_nxt   = {q_r[HANDLE_W-2:0], 1'b0};
        end
        dvd_nxt = {dvd_r[HANDLE_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          state_nxt = S_FCHK;
        end
      end

      S_FCHK: begin
        if (q_r < HANDLE_W'(NUM_BLOCKS) && taken_r[q_r[BW-1:0]]) begin
          b_nxt     = q_r[BW-1:0];
          slot_nxt  = SLW'(rem_r);
          bm_ra     = q_r[BW-1:0];
          ln_ra     = q_r[BW-1:0];
          lp_ra     = q_r[BW-1:0];
          sm_ra     = slot_addr(q_r[BW-1:0], SLW'(rem_r));
          state_nxt = S_FREE;
        end else begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_BAD_FREE;
          hout_nxt      = '0;
          rel_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      S_FREE: begin
        out_valid_nxt = 1'b1;
        hout_nxt      = '0;
        state_nxt     = S_IDLE;
        if (!sm_rd_r[SMW-1] || (CW'(slot_r) < f_fr)) begin
          // slot is not out: double free or never handed out
          status_nxt = ST_BAD_FREE;
          rel_nxt    = 1'b0;
        end else begin
          status_nxt = ST_OK;
          sm_we      = 1'b1;
          sm_wa      = slot_addr(b_r, slot_r);
          sm_wd      = {1'b0, ((f_fc > f_fr) && (f_top < MAXC)) ? SLW'(f_top) : f_link};
          bm_we      = 1'b1;
          bm_wa      = b_r;
          if (f_rel) begin
            taken_nxt[b_r] = 1'b0;
            bm_wd          = {CW'(0), CW'(0), MAXC};
            rel_nxt        = 1'b1;
            if (!f_full) begin
              // unlink from the list, updating the head when it has no predecessor
              if (lp_rd_r != NONE) begin
                ln_we = 1'b1;
                ln_wa = lp_rd_r[BW-1:0];
                ln_wd = ln_rd_r;
              end else begin
                head_nxt = ln_rd_r;
              end
              if (ln_rd_r != NONE) begin
                lp_we = 1'b1;
                lp_wa = ln_rd_r[BW-1:0];
                lp_wd = lp_rd_r;
              end
            end
          end else begin
            rel_nxt = 1'b0;
            bm_wd   = {f_fc + CW'(1), f_fr, CW'(slot_r)};
            if (f_full) begin
              // push the block back on the list head
              lp_we     = 1'b1;
              lp_wa     = b_r;
              lp_wd     = NONE;
              ln_we     = 1'b1;
              ln_wa     = b_r;
              ln_wd     = head_r;
              head_nxt  = LW'(b_r);
              hnext_nxt = head_r;
              if (head_r != NONE) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_FIX;
              end
            end
          end
        end
      end

      S_FIX: begin
        lp_we         = 1'b1;
        lp_wa         = hnext_r[BW-1:0];
        lp_wd         = LW'(b_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_alloc) begin
      bm_we    = 1'b1;
      bm_wa    = b_r;
      bm_wd    = {fc_r - CW'(1), a_fr, a_top};
      sm_we    = 1'b1;
      sm_wa    = slot_addr(b_r, a_slot);
      sm_wd    = {1'b1, SLW'(0)};
      if (fc_r == CW'(1)) begin
        // block is now full: drop it from the list head
        head_nxt = hnext_r;
        if (hnext_r != NONE) begin
          lp_we = 1'b1;
          lp_wa = hnext_r[BW-1:0];
          lp_wd = NONE;
        end
      end
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      hout_nxt      = HANDLE_W'(int'(b_r) * int'(s_eff) + int'(a_slot));
      rel_nxt       = 1'b0;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taken_r     <= '0;
      head_r      <= NONE;
      slots_r     <= SLOTS_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      head_r      <= head_nxt;
      slots_r     <= slots_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r      <= b_nxt;
    slot_r   <= slot_nxt;
    fc_r     <= fc_nxt;
    fr_r     <= fr_nxt;
    top_r    <= top_nxt;
    hnext_r  <= hnext_nxt;
    dvd_r    <= dvd_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    rel_r    <= rel_nxt;
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_rd_r <= bm_mem[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (ln_we) ln_mem[ln_wa] <= ln_wd;
    ln_rd_r <= ln_mem[ln_ra];
  end

  always_ff @(posedge clk) begin
    if (lp_we) lp_mem[lp_wa] <= lp_wd;
    lp_rd_r <= lp_mem[lp_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_wa] <= sm_wd;
    sm_rd_r <= sm_mem[sm_ra];
  end

  assign in_ch.ready           = in_ready;
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.slot_handle    = hout_r;
  assign out_ch.block_released = rel_r;

  a_head_taken: assert property (@(posedge clk) disable iff (!rst_n)
    head_r != NONE |-> taken_r[head_r[BW-1:0]])
    else $error("list head names a block that is not taken");

  a_exhausted_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EXHAUSTED |-> &taken_r)
    else $error("pool exhausted reported with a free block");

  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rel_r |-> status_r == ST_OK)
    else $error("block released on a failed request");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r != '0)
    else $error("divider running with zero step count");

endmodule
`default_nettype wire
